// ===== rtl/sha1_byte_stream_hash_assert.svh =====
// Assertion macros shared by the hash block. The clock and reset names are the
// block's own port names.
`ifndef SHA1_BYTE_STREAM_HASH_ASSERT_SVH
`define SHA1_BYTE_STREAM_HASH_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHA1BS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SHA1BS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sha1bs_pkg.sv =====
`timescale 1ns / 1ps

package sha1bs_pkg;

    // Geometry of the chaining value and of the message block.
    localparam int CHAIN_WORDS = 5;
    localparam int CHAIN_AW    = $clog2(CHAIN_WORDS);
    localparam int MSG_WORDS   = 16;
    localparam int MSG_AW      = $clog2(MSG_WORDS);
    localparam int ROUNDS      = 80;
    localparam int RIDX_W      = $clog2(ROUNDS);
    localparam int COUNT_W     = 61;

    // Padding constants.
    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;
    localparam logic [5:0] FILL_LAST  = 6'd63;

    // Round constants.
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_LOAD,
        S_ROUND,
        S_WB,
        S_ORD,
        S_OWAIT
    } t_state;

    // Controls from the sequencer to the round datapath.
    typedef struct packed {
        logic              shift;
        logic              round;
        logic [RIDX_W-1:0] idx;
    } t_core_ctl;

    // Initial hash value for one chaining word.
    function automatic logic [31:0] f_iv(input logic [CHAIN_AW-1:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0:    v = 32'h67452301;
            3'd1:    v = 32'hEFCDAB89;
            3'd2:    v = 32'h98BADCFE;
            3'd3:    v = 32'h10325476;
            3'd4:    v = 32'hC3D2E1F0;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/sha1bs_ram.sv =====
`timescale 1ns / 1ps

module sha1bs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/sha1bs_core.sv =====
`timescale 1ns / 1ps

module sha1bs_core
    import sha1bs_pkg::*;
(
    input  logic        i_clk,
    input  t_core_ctl   i_ctl,
    input  logic [31:0] i_shift_data,
    input  logic [31:0] i_msg_word,
    output logic [31:0] o_head
);

    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] r_win [MSG_WORDS];
    logic [31:0] w_sched;
    logic [31:0] w_word;
    logic [31:0] w_f;
    logic [31:0] w_k;
    logic [31:0] w_temp;

    // Schedule word: the first sixteen come from the block, the rest from the window.
    always_comb begin
        w_sched = r_win[13] ^ r_win[8] ^ r_win[2] ^ r_win[0];
        if (i_ctl.idx < RIDX_W'(MSG_WORDS)) begin
            w_word = i_msg_word;
        end else begin
            w_word = {w_sched[30:0], w_sched[31]};
        end
    end

    // Round function and constant by round group.
    always_comb begin
        if (i_ctl.idx < RIDX_W'(20)) begin
            w_f = (r_b & r_c) | (~r_b & r_d);
            w_k = K0;
        end else if (i_ctl.idx < RIDX_W'(40)) begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = K1;
        end else if (i_ctl.idx < RIDX_W'(60)) begin
            w_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            w_k = K2;
        end else begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = K3;
        end
        w_temp = {r_a[26:0], r_a[31:27]} + w_f + r_e + w_k + w_word;
    end

    // Working variables: a round, or a shift toward the head for load and write-back.
    always_ff @(posedge i_clk) begin
        if (i_ctl.round) begin
            r_a <= w_temp;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end else if (i_ctl.shift) begin
            r_a <= r_b;
            r_b <= r_c;
            r_c <= r_d;
            r_d <= r_e;
            r_e <= i_shift_data;
        end
    end

    // Sixteen-word schedule window, oldest word at index zero.
    always_ff @(posedge i_clk) begin
        if (i_ctl.round) begin
            for (int i = 0; i < MSG_WORDS - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[MSG_WORDS-1] <= w_word;
        end
    end

    assign o_head = r_a;

endmodule

// ===== rtl/sha1_byte_stream_hash.sv =====
`timescale 1ns / 1ps

// SHA-1 over a byte stream. Each input beat may carry one message byte and the
// end-of-message mark. When a 64-byte block fills, the block stalls its input
// for a compression (reading the chaining memory, 80 rounds at one per cycle
// through one round unit, then read-add-write back). On finish the padding and
// the 64-bit length go through the same byte path at one byte per cycle,
// followed by one or two compressions; the five digest words then leave one at
// a time, word 0 first, each read from the chaining memory, the next only once
// the previous one has been taken. The input is stalled whenever the block is
// not idle.

`include "sha1_byte_stream_hash_assert.svh"

module sha1_byte_stream_hash
    import sha1bs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_finish,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    t_state              r_state, n_state;
    logic [RIDX_W-1:0]   r_cnt, n_cnt;
    logic [5:0]          r_fill, n_fill;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic [23:0]         r_asm, n_asm;
    logic                r_fin, n_fin;
    logic                r_sent80, n_sent80;
    logic                r_len, n_len;
    logic                r_fresh, n_fresh;
    logic [CHAIN_AW-1:0] r_craddr, n_craddr;
    logic [CHAIN_AW-1:0] r_widx, n_widx;
    logic                r_ovalid, n_ovalid;
    logic [31:0]         r_odata, n_odata;
    logic [2:0]          r_oidx, n_oidx;

    logic                c_we, c_re;
    logic [CHAIN_AW-1:0] c_waddr, c_raddr;
    logic [31:0]         c_wdata, c_rdata, chain_rd;
    logic                m_we, m_re;
    logic [MSG_AW-1:0]   m_waddr, m_raddr;
    logic [31:0]         m_wdata, m_rdata;
    t_core_ctl           core_ctl;
    logic [31:0]         core_head;
    logic                put_en;
    logic [7:0]          put_data;
    logic                len_now;
    logic [63:0]         len_shift;
    logic [7:0]          pad_byte;

    // Chaining value and message block memories.
    sha1bs_ram #(.WIDTH(32), .DEPTH(CHAIN_WORDS)) u_chain (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_re    (c_re),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    sha1bs_ram #(.WIDTH(32), .DEPTH(MSG_WORDS)) u_msg (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_re    (m_re),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    sha1bs_core u_core (
        .i_clk        (i_clk),
        .i_ctl        (core_ctl),
        .i_shift_data (chain_rd),
        .i_msg_word   (m_rdata),
        .o_head       (core_head)
    );

    // Until the first write-back after a digest, the chaining memory reads as the IV.
    assign chain_rd = r_fresh ? f_iv(r_craddr) : c_rdata;

    // Padding byte: the marker, then zeros, then the bit length most significant first.
    always_comb begin
        len_now   = r_sent80 && (r_len || (r_fill == LEN_OFFSET));
        len_shift = {r_count, 3'b000} << {r_fill[2:0], 3'b000};
        if (!r_sent80) begin
            pad_byte = PAD_BYTE;
        end else if (len_now) begin
            pad_byte = len_shift[63:56];
        end else begin
            pad_byte = 8'h00;
        end
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state, memory accesses and datapath controls.
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_fill   = r_fill;
        n_count  = r_count;
        n_asm    = r_asm;
        n_fin    = r_fin;
        n_sent80 = r_sent80;
        n_len    = r_len;
        n_fresh  = r_fresh;
        n_craddr = r_craddr;
        n_widx   = r_widx;
        n_ovalid = r_ovalid && i_stall;
        n_odata  = r_odata;
        n_oidx   = r_oidx;
        c_we     = 1'b0;
        c_waddr  = '0;
        c_wdata  = chain_rd + core_head;
        c_re     = 1'b0;
        c_raddr  = '0;
        m_we     = 1'b0;
        m_waddr  = r_fill[5:2];
        m_re     = 1'b0;
        m_raddr  = '0;
        core_ctl = '{shift: 1'b0, round: 1'b0, idx: r_cnt};
        put_en   = 1'b0;
        put_data = i_data_byte;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_has_byte) begin
                        put_en  = 1'b1;
                        n_count = r_count + 1'b1;
                    end
                    if (i_finish) begin
                        n_fin = 1'b1;
                    end
                    if (i_has_byte && (r_fill == FILL_LAST)) begin
                        n_state = S_LOAD;
                        n_cnt   = '0;
                    end else if (i_finish) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                put_en   = 1'b1;
                put_data = pad_byte;
                if (!r_sent80) begin
                    n_sent80 = 1'b1;
                end else if (len_now) begin
                    n_len = 1'b1;
                end
                if (r_fill == FILL_LAST) begin
                    n_state = S_LOAD;
                    n_cnt   = '0;
                end
            end
            S_LOAD: begin
                if (r_cnt < RIDX_W'(CHAIN_WORDS)) begin
                    c_re    = 1'b1;
                    c_raddr = r_cnt[CHAIN_AW-1:0];
                end
                if (r_cnt != '0) begin
                    core_ctl.shift = 1'b1;
                end
                if (r_cnt == RIDX_W'(CHAIN_WORDS)) begin
                    m_re    = 1'b1;
                    m_raddr = '0;
                    n_cnt   = '0;
                    n_state = S_ROUND;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_ROUND: begin
                core_ctl.round = 1'b1;
                if (r_cnt < RIDX_W'(MSG_WORDS - 1)) begin
                    m_re    = 1'b1;
                    m_raddr = r_cnt[MSG_AW-1:0] + 1'b1;
                end
                if (r_cnt == RIDX_W'(ROUNDS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_WB;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_WB: begin
                if (r_cnt < RIDX_W'(CHAIN_WORDS)) begin
                    c_re    = 1'b1;
                    c_raddr = r_cnt[CHAIN_AW-1:0];
                end
                if (r_cnt != '0) begin
                    c_we           = 1'b1;
                    c_waddr        = r_cnt[CHAIN_AW-1:0] - 1'b1;
                    core_ctl.shift = 1'b1;
                end
                if (r_cnt == RIDX_W'(CHAIN_WORDS)) begin
                    n_cnt   = '0;
                    n_fresh = 1'b0;
                    if (!r_fin) begin
                        n_state = S_IDLE;
                    end else if (r_len) begin
                        n_state = S_ORD;
                    end else begin
                        n_state = S_PAD;
                    end
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_ORD: begin
                if (!r_ovalid) begin
                    c_re    = 1'b1;
                    c_raddr = r_widx;
                    n_state = S_OWAIT;
                end
            end
            S_OWAIT: begin
                n_odata  = chain_rd;
                n_ovalid = 1'b1;
                n_oidx   = 3'(r_widx);
                if (r_widx == CHAIN_AW'(CHAIN_WORDS - 1)) begin
                    n_fresh  = 1'b1;
                    n_fill   = '0;
                    n_count  = '0;
                    n_fin    = 1'b0;
                    n_sent80 = 1'b0;
                    n_len    = 1'b0;
                    n_widx   = '0;
                    n_state  = S_IDLE;
                end else begin
                    n_widx  = r_widx + 1'b1;
                    n_state = S_ORD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Byte path: gather four bytes, write the word, wrap the fill index.
        m_wdata = {r_asm, put_data};
        if (put_en) begin
            n_asm  = {r_asm[15:0], put_data};
            n_fill = r_fill + 1'b1;
            if (r_fill[1:0] == 2'b11) begin
                m_we = 1'b1;
            end
        end
        if (c_re) begin
            n_craddr = c_raddr;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_fill   <= '0;
            r_count  <= '0;
            r_fin    <= 1'b0;
            r_sent80 <= 1'b0;
            r_len    <= 1'b0;
            r_fresh  <= 1'b1;
            r_widx   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_cnt    <= n_cnt;
            r_fill   <= n_fill;
            r_count  <= n_count;
            r_fin    <= n_fin;
            r_sent80 <= n_sent80;
            r_len    <= n_len;
            r_fresh  <= n_fresh;
            r_widx   <= n_widx;
            r_ovalid <= n_ovalid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_asm    <= n_asm;
        r_craddr <= n_craddr;
        r_odata  <= n_odata;
        r_oidx   <= n_oidx;
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_ovalid;
    assign o_digest_word = r_odata;
    assign o_word_index  = r_oidx;
    assign o_last_word   = (r_oidx == 3'(CHAIN_WORDS - 1));

    // A compression starts only when the block has just filled.
    `SHA1BS_ASSERT_NOW(a_load_on_full, (r_state != S_LOAD) && (n_state == S_LOAD), r_fill == FILL_LAST, "compression started on a partial block")
    // A digest word is never loaded over one that is still waiting.
    `SHA1BS_ASSERT_NOW(a_out_free, r_state == S_OWAIT, !r_ovalid, "digest word overwritten")
    // The length bytes belong only to a message that is finishing.
    `SHA1BS_ASSERT_NOW(a_len_fin, r_len, r_fin && r_sent80, "length phase outside finish")
    // After the last digest word the chaining value reads as the IV again.
    `SHA1BS_ASSERT_NEXT(a_iv_back, (r_state == S_OWAIT) && (r_widx == CHAIN_AW'(CHAIN_WORDS - 1)), r_fresh && (r_fill == '0) && (r_count == '0), "state not restored after digest")

endmodule
